>>> rtl/rpb_pkg.sv
`timescale 1ns / 1ps

package rpb_pkg;

  // blend mode codes
  localparam logic [1:0] MODE_MULTIPLY = 2'd0;
  localparam logic [1:0] MODE_SUBTRACT = 2'd1;
  localparam logic [1:0] MODE_SCREEN   = 2'd2;
  localparam logic [1:0] MODE_OVERLAY  = 2'd3;

  localparam int unsigned ChanW = 8;

  // load enables of the four datapath stages
  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
    logic s4_en;
  } rpb_pipe_en_t;

endpackage

>>> rtl/rpb_channel.sv
`timescale 1ns / 1ps

module rpb_channel import rpb_pkg::*; (
  input  logic             clk_i,
  input  rpb_pipe_en_t     pipe_en_i,
  input  logic [1:0]       mode_i,
  input  logic [ChanW-1:0] top_i,
  input  logic [ChanW-1:0] bottom_i,
  output logic [ChanW-1:0] out_o
);

  // stage 1: operand preparation
  logic [ChanW-1:0] p_d, m_d, byp_val_d;
  logic             dbl_d, inv_d, byp_d;
  logic [ChanW-1:0] p_q, m_q, byp_val1_q;
  logic             dbl1_q, inv1_q, byp1_q;

  always_comb begin
    p_d       = top_i;
    m_d       = bottom_i;
    dbl_d     = 1'b0;
    inv_d     = 1'b0;
    byp_d     = 1'b0;
    byp_val_d = '0;
    case (mode_i)
      MODE_MULTIPLY: begin
        p_d = top_i;
        m_d = bottom_i;
      end
      MODE_SUBTRACT: begin
        byp_d     = 1'b1;
        byp_val_d = (bottom_i >= top_i) ? (bottom_i - top_i) : '0;
      end
      MODE_SCREEN: begin
        p_d   = ~top_i;
        m_d   = ~bottom_i;
        inv_d = 1'b1;
      end
      MODE_OVERLAY: begin
        dbl_d = 1'b1;
        if (bottom_i[ChanW-1]) begin
          p_d   = ~top_i;
          m_d   = ~bottom_i;
          inv_d = 1'b1;
        end
      end
      default: begin
        p_d = top_i;
        m_d = bottom_i;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en_i.s1_en) begin
      p_q        <= p_d;
      m_q        <= m_d;
      dbl1_q     <= dbl_d;
      inv1_q     <= inv_d;
      byp1_q     <= byp_d;
      byp_val1_q <= byp_val_d;
    end
  end

  // stage 2: product
  logic [15:0]      prod_q;
  logic             dbl2_q, inv2_q, byp2_q;
  logic [ChanW-1:0] byp_val2_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en_i.s2_en) begin
      prod_q     <= p_q * m_q;
      dbl2_q     <= dbl1_q;
      inv2_q     <= inv1_q;
      byp2_q     <= byp1_q;
      byp_val2_q <= byp_val1_q;
    end
  end

  // stage 3: rounding offset and quotient estimate, t*257/65536 is t/255 or one below
  logic [16:0]      t_d;
  logic [24:0]      t257;
  logic [16:0]      t_q;
  logic [8:0]       qe_q;
  logic             inv3_q, byp3_q;
  logic [ChanW-1:0] byp_val3_q;

  assign t_d  = (dbl2_q ? {prod_q, 1'b0} : {1'b0, prod_q}) + 17'd127;
  assign t257 = {t_d, 8'd0} + {8'd0, t_d};

  always_ff @(posedge clk_i) begin
    if (pipe_en_i.s3_en) begin
      t_q        <= t_d;
      qe_q       <= t257[24:16];
      inv3_q     <= inv2_q;
      byp3_q     <= byp2_q;
      byp_val3_q <= byp_val2_q;
    end
  end

  // stage 4: correction and final select
  logic [17:0]      qe255;
  logic [17:0]      rem;
  logic [8:0]       q;
  logic [ChanW-1:0] res_d, res_q;

  assign qe255 = {1'b0, qe_q, 8'd0} - {9'd0, qe_q};
  assign rem   = {1'b0, t_q} - qe255;
  assign q     = qe_q + {8'd0, (rem >= 18'd255)};

  always_comb begin
    if (byp3_q) begin
      res_d = byp_val3_q;
    end else if (inv3_q) begin
      res_d = 8'd255 - q[ChanW-1:0];
    end else begin
      res_d = q[ChanW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en_i.s4_en) begin
      res_q <= res_d;
    end
  end

  assign out_o = res_q;

endmodule

>>> rtl/rgb_pixel_blend.sv
`timescale 1ns / 1ps

// Per-pixel blend of a top and a bottom BGR pixel, eight bits per channel.
// Input channel: in_valid_i / in_ready_o with the six channel values and
// in_last_i. Output channel: out_valid_o / out_ready_i with the three
// blended values and out_last_o. A word moves when valid and ready are high.
// blend_mode_we_i writes blend_mode_wdata_i into the mode register at once;
// write it only while no pixel is in flight.
// A word taken in moves through the register stages in order and leaves from the last.
// Throughput is one pixel per cycle unless the receiver stalls: four register stages
// (operand prep, 8x8 multiply, rounding with reciprocal estimate, correction and
// select) each with its own valid bit, one lane per colour channel.
// When the receiver stalls, the words move up to fill empty stages and
// in_ready_o drops only once all four stages hold a word.
// Reset empties the pipeline and sets the mode to multiply.
module rgb_pixel_blend import rpb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             blend_mode_we_i,
  input  logic [1:0]       blend_mode_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ChanW-1:0] top_blue_i,
  input  logic [ChanW-1:0] top_green_i,
  input  logic [ChanW-1:0] top_red_i,
  input  logic [ChanW-1:0] bottom_blue_i,
  input  logic [ChanW-1:0] bottom_green_i,
  input  logic [ChanW-1:0] bottom_red_i,
  input  logic             in_last_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ChanW-1:0] out_blue_o,
  output logic [ChanW-1:0] out_green_o,
  output logic [ChanW-1:0] out_red_o,
  output logic             out_last_o
);

  logic [1:0]   mode_q;
  logic [3:0]   valid_q;
  logic [3:0]   last_q;
  rpb_pipe_en_t pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MULTIPLY;
    end else if (blend_mode_we_i) begin
      mode_q <= blend_mode_wdata_i;
    end
  end

  // a stage loads when it is empty or its word moves on
  assign pipe_en.s4_en = !valid_q[3] || out_ready_i;
  assign pipe_en.s3_en = !valid_q[2] || pipe_en.s4_en;
  assign pipe_en.s2_en = !valid_q[1] || pipe_en.s3_en;
  assign pipe_en.s1_en = !valid_q[0] || pipe_en.s2_en;
  assign in_ready_o    = pipe_en.s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (pipe_en.s1_en) valid_q[0] <= in_valid_i;
      if (pipe_en.s2_en) valid_q[1] <= valid_q[0];
      if (pipe_en.s3_en) valid_q[2] <= valid_q[1];
      if (pipe_en.s4_en) valid_q[3] <= valid_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en.s1_en) last_q[0] <= in_last_i;
    if (pipe_en.s2_en) last_q[1] <= last_q[0];
    if (pipe_en.s3_en) last_q[2] <= last_q[1];
    if (pipe_en.s4_en) last_q[3] <= last_q[2];
  end

  rpb_channel u_blue (
    .clk_i     (clk_i),
    .pipe_en_i (pipe_en),
    .mode_i    (mode_q),
    .top_i     (top_blue_i),
    .bottom_i  (bottom_blue_i),
    .out_o     (out_blue_o)
  );

  rpb_channel u_green (
    .clk_i     (clk_i),
    .pipe_en_i (pipe_en),
    .mode_i    (mode_q),
    .top_i     (top_green_i),
    .bottom_i  (bottom_green_i),
    .out_o     (out_green_o)
  );

  rpb_channel u_red (
    .clk_i     (clk_i),
    .pipe_en_i (pipe_en),
    .mode_i    (mode_q),
    .top_i     (top_red_i),
    .bottom_i  (bottom_red_i),
    .out_o     (out_red_o)
  );

  assign out_valid_o = valid_q[3];
  assign out_last_o  = last_q[3];

`ifndef SYNTHESIS
  // back-pressure only when every stage is full and the output is held
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (valid_q == 4'hf) && !out_ready_i)
    else $error("input stalled with a free stage");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[0])
    else $error("accepted word not in first stage");

  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en.s4_en |=> $stable(out_blue_o) && $stable(out_red_o) && $stable(out_last_o))
    else $error("output word changed while held");

  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1] && !pipe_en.s3_en |=> valid_q[1] && valid_q[2])
    else $error("stalled word lost in the pipeline");
`endif

endmodule

>>> dv/tb_rgb_pixel_blend.sv
`timescale 1ns / 1ps

module tb_rgb_pixel_blend import rpb_pkg::*;;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxReports = 30;

  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } bgr_t;

  typedef struct {
    bgr_t top;
    bgr_t bottom;
    logic last;
  } pixel_pair_t;

  typedef struct {
    bgr_t px;
    logic last;
  } blended_word_t;

  class blend_scoreboard;
    logic [1:0]    mode = MODE_MULTIPLY;
    blended_word_t expected_words[$];
    int unsigned   errors = 0;

    static function logic [ChanW-1:0] blend_chan(logic [1:0] m, logic [ChanW-1:0] top,
                                                 logic [ChanW-1:0] bot);
      int unsigned a, b, r;
      a = top;
      b = bot;
      case (m)
        MODE_MULTIPLY: r = (a * b + 127) / 255;
        MODE_SUBTRACT: r = (b >= a) ? b - a : 0;
        MODE_SCREEN: begin
          if (a == 0) r = b;
          else if (a == 255) r = 255;
          else r = 255 - ((255 - a) * (255 - b) + 127) / 255;
        end
        default: begin
          if (b <= 127) r = (2 * a * b + 127) / 255;
          else r = 255 - (2 * (255 - a) * (255 - b) + 127) / 255;
        end
      endcase
      return r[ChanW-1:0];
    endfunction

    function void note_pixel(pixel_pair_t p);
      blended_word_t w;
      w.px.blue  = blend_chan(mode, p.top.blue, p.bottom.blue);
      w.px.green = blend_chan(mode, p.top.green, p.bottom.green);
      w.px.red   = blend_chan(mode, p.top.red, p.bottom.red);
      w.last     = p.last;
      expected_words = {expected_words, w};
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MaxReports) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_word(blended_word_t got);
      blended_word_t want;
      if (expected_words.size() == 0) begin
        report_mismatch("output word with nothing outstanding");
        return;
      end
      want = expected_words.pop_front();
      if (got.px.blue !== want.px.blue)
        report_mismatch($sformatf("blue %0d, want %0d, mode %0d", got.px.blue, want.px.blue,
                                  mode));
      if (got.px.green !== want.px.green)
        report_mismatch($sformatf("green %0d, want %0d, mode %0d", got.px.green,
                                  want.px.green, mode));
      if (got.px.red !== want.px.red)
        report_mismatch($sformatf("red %0d, want %0d, mode %0d", got.px.red, want.px.red,
                                  mode));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b, want %b", got.last, want.last));
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             blend_mode_we_i;
  logic [1:0]       blend_mode_wdata_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [ChanW-1:0] top_blue_i, top_green_i, top_red_i;
  logic [ChanW-1:0] bottom_blue_i, bottom_green_i, bottom_red_i;
  logic             in_last_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [ChanW-1:0] out_blue_o, out_green_o, out_red_o;
  logic             out_last_o;

  blend_scoreboard  sb;
  bit               tx_calm;

  always #5 clk_i = ~clk_i;

  rgb_pixel_blend dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .blend_mode_we_i   (blend_mode_we_i),
    .blend_mode_wdata_i(blend_mode_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .top_blue_i        (top_blue_i),
    .top_green_i       (top_green_i),
    .top_red_i         (top_red_i),
    .bottom_blue_i     (bottom_blue_i),
    .bottom_green_i    (bottom_green_i),
    .bottom_red_i      (bottom_red_i),
    .in_last_i         (in_last_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_blue_o        (out_blue_o),
    .out_green_o       (out_green_o),
    .out_red_o         (out_red_o),
    .out_last_o        (out_last_o)
  );

  // all driving tasks are entered and left on a falling edge
  task automatic write_mode(logic [1:0] m);
    blend_mode_we_i    <= 1'b1;
    blend_mode_wdata_i <= m;
    @(negedge clk_i);
    blend_mode_we_i <= 1'b0;
    sb.mode = m;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.expected_words.size() != 0);
  endtask

  task automatic send_pixel(pixel_pair_t p, int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    top_blue_i     <= p.top.blue;
    top_green_i    <= p.top.green;
    top_red_i      <= p.top.red;
    bottom_blue_i  <= p.bottom.blue;
    bottom_green_i <= p.bottom.green;
    bottom_red_i   <= p.bottom.red;
    in_last_i      <= p.last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(p);
    @(negedge clk_i);
  endtask

  // bias towards the corners and the overlay threshold around 127/128
  function automatic logic [ChanW-1:0] rand_chan();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return ChanW'($urandom_range(126, 129));
      default: return ChanW'($urandom);
    endcase
  endfunction

  function automatic pixel_pair_t rand_pixel();
    pixel_pair_t p;
    p.top.blue     = rand_chan();
    p.top.green    = rand_chan();
    p.top.red      = rand_chan();
    p.bottom.blue  = rand_chan();
    p.bottom.green = rand_chan();
    p.bottom.red   = rand_chan();
    p.last         = ($urandom_range(0, 15) == 0);
    return p;
  endfunction

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("rgb_pixel_blend test failed");
    $finish;
  end

  // output side
  initial begin
    blended_word_t w;
    int unsigned   stall;
    bit            rx_calm;
    rx_calm     = 1'b0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      w.px.blue  = out_blue_o;
      w.px.green = out_green_o;
      w.px.red   = out_red_o;
      w.last     = out_last_o;
      sb.check_word(w);
      @(negedge clk_i);
    end
  end

  initial begin
    pixel_pair_t corner_px[6];
    int unsigned phase_len;

    rst_ni             = 1'b0;
    blend_mode_we_i    = 1'b0;
    blend_mode_wdata_i = MODE_MULTIPLY;
    in_valid_i         = 1'b0;
    top_blue_i         = '0;
    top_green_i        = '0;
    top_red_i          = '0;
    bottom_blue_i      = '0;
    bottom_green_i     = '0;
    bottom_red_i       = '0;
    in_last_i          = 1'b0;
    tx_calm            = 1'b0;
    sb                 = new();

    // top {blue, green, red}, bottom {blue, green, red}, last
    corner_px[0] = '{'{8'd0, 8'd0, 8'd255}, '{8'd0, 8'd255, 8'd0}, 1'b0};
    corner_px[1] = '{'{8'd255, 8'd1, 8'd254}, '{8'd255, 8'd254, 8'd1}, 1'b0};
    corner_px[2] = '{'{8'd127, 8'd128, 8'd127}, '{8'd127, 8'd127, 8'd128}, 1'b1};
    corner_px[3] = '{'{8'd128, 8'd0, 8'd255}, '{8'd128, 8'd200, 8'd127}, 1'b0};
    corner_px[4] = '{'{8'd100, 8'd200, 8'd55}, '{8'd200, 8'd100, 8'd55}, 1'b0};
    corner_px[5] = '{'{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255}, 1'b1};

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed corners under every mode, the first pass on the reset mode
    for (int m = 0; m < 4; m++) begin
      if (m != 0) begin
        wait_drained();
        write_mode(m[1:0]);
      end
      foreach (corner_px[i]) send_pixel(corner_px[i], $urandom_range(0, 3));
    end

    for (int phase = 0; phase < 8; phase++) begin
      wait_drained();
      // each mode once from overlay down to multiply, then random settings
      write_mode(phase < 4 ? 2'(3 - phase) : 2'($urandom_range(0, 3)));
      phase_len = $urandom_range(200, 290);
      for (int i = 0; i < phase_len; i++) begin
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        if ($urandom_range(0, 299) == 0) wait_drained();
        send_pixel(rand_pixel(), tx_calm ? 0 : $urandom_range(0, 15));
      end
    end

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (sb.expected_words.size() != 0)
      sb.report_mismatch($sformatf("%0d words never arrived", sb.expected_words.size()));
    if (sb.errors == 0) begin
      $display("rgb_pixel_blend test passed");
    end else begin
      $display("rgb_pixel_blend test failed");
    end
    $finish;
  end

endmodule
